>>> rtl/mlp_pkg.sv
package mlp_pkg;

    // network shape
    localparam int FEATURES     = 16;
    localparam int HIDDEN_UNITS = 8;
    localparam int OUTPUTS      = 2;

    localparam int HW_DEPTH = HIDDEN_UNITS * FEATURES;
    localparam int OW_DEPTH = OUTPUTS * HIDDEN_UNITS;

    localparam int FEAT_AW = $clog2(FEATURES);
    localparam int HID_AW  = (HIDDEN_UNITS > 1) ? $clog2(HIDDEN_UNITS) : 1;
    localparam int HW_AW   = $clog2(HW_DEPTH);
    localparam int OW_AW   = $clog2(OW_DEPTH);
    localparam int XA_W    = (FEAT_AW > HID_AW) ? FEAT_AW : HID_AW;

    // field widths
    localparam int VAL_W    = 16;
    localparam int WIDX_W   = 7;
    localparam int MODE_W   = 2;
    localparam int LOGIT_W  = 24;
    localparam int PROD_W   = 2 * VAL_W;
    localparam int MAX_TERMS = (FEATURES > HIDDEN_UNITS) ? FEATURES : HIDDEN_UNITS;
    localparam int ACC_W    = PROD_W + $clog2(MAX_TERMS);
    localparam int FRAC_BITS = 8;

    // stream packing
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 56;

    // item kinds on s_tuser
    localparam logic [MODE_W-1:0] MODE_HIDDEN_WEIGHT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_OUTPUT_WEIGHT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FEATURE       = 2'd2;

    // register indexes
    localparam logic CFG_HIDDEN_BIAS = 1'b0;
    localparam logic CFG_OUTPUT_BIAS = 1'b1;

    // layer select on the MAC
    localparam logic LAYER_HID = 1'b0;
    localparam logic LAYER_OUT = 1'b1;

    // decision codes
    localparam logic DEC_NEG = 1'b0;
    localparam logic DEC_POS = 1'b1;

    typedef struct packed {
        logic              valid;
        logic              layer;
        logic              first;
        logic              last;
        logic [HID_AW-1:0] idx;
    } pipe_tag_t;

    typedef struct packed {
        pipe_tag_t         tag;
        logic [XA_W-1:0]   x_addr;
        logic [HW_AW-1:0]  w_addr;
    } mac_cmd_t;

    typedef struct packed {
        logic               hw_we;
        logic               ow_we;
        logic               feat_we;
        logic [FEAT_AW-1:0] feat_addr;
    } wr_cmd_t;

    typedef struct packed {
        wr_cmd_t  wr;
        mac_cmd_t mac;
        logic     load_out;
    } dp_ctrl_t;

    typedef struct packed {
        logic busy;
        logic out_free;
    } dp_status_t;

endpackage

>>> rtl/mlp_datapath.sv
module mlp_datapath
    import mlp_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_we,
    input  logic                     cfg_index,
    input  logic [VAL_W-1:0]         cfg_wdata,
    input  logic [WIDX_W-1:0]        in_weight_index,
    input  logic [VAL_W-1:0]         in_value,
    input  dp_ctrl_t                 ctrl,
    output dp_status_t               status,
    input  logic                     m_tready,
    output logic                     m_tvalid,
    output logic signed [LOGIT_W-1:0] out_logit_neg,
    output logic signed [LOGIT_W-1:0] out_logit_pos,
    output logic                     out_decision
);

    localparam logic signed [ACC_W:0] HID_MAX   = (ACC_W+1)'(32767);
    localparam logic signed [ACC_W:0] LOGIT_MAX = (ACC_W+1)'(2**(LOGIT_W-1) - 1);
    localparam logic signed [ACC_W:0] LOGIT_MIN = -(ACC_W+1)'(2**(LOGIT_W-1));

    logic signed [VAL_W-1:0] hw_mem   [HW_DEPTH];
    logic signed [VAL_W-1:0] ow_mem   [OW_DEPTH];
    logic signed [VAL_W-1:0] feat_mem [FEATURES];
    logic signed [VAL_W-1:0] hval_mem [HIDDEN_UNITS];

    logic signed [VAL_W-1:0] hidden_bias_reg, output_bias_reg;
    logic signed [VAL_W-1:0] hw_q_reg, ow_q_reg, feat_q_reg, hval_q_reg;
    pipe_tag_t               s1_reg, s2_reg, s3_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [LOGIT_W-1:0] logit_reg [OUTPUTS];
    logic                     m_tvalid_reg;
    logic signed [LOGIT_W-1:0] out_neg_reg, out_pos_reg;
    logic                     out_dec_reg;

    logic signed [VAL_W-1:0] mul_a, mul_b;
    logic signed [ACC_W-1:0] acc_shifted;
    logic signed [ACC_W:0]   biased;
    logic signed [VAL_W-1:0] hid_sat;
    logic signed [LOGIT_W-1:0] logit_sat;
    logic                    fin_hid, fin_out;

    // bias registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hidden_bias_reg <= 16'sd256;
            output_bias_reg <= 16'sd256;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_HIDDEN_BIAS: hidden_bias_reg <= cfg_wdata;
                CFG_OUTPUT_BIAS: output_bias_reg <= cfg_wdata;
            endcase
        end
    end

    // weight and feature stores, registered reads
    always_ff @(posedge aclk) begin
        if (ctrl.wr.hw_we) begin
            hw_mem[in_weight_index[HW_AW-1:0]] <= in_value;
        end
        hw_q_reg <= hw_mem[ctrl.mac.w_addr];
    end

    always_ff @(posedge aclk) begin
        if (ctrl.wr.ow_we) begin
            ow_mem[in_weight_index[OW_AW-1:0]] <= in_value;
        end
        ow_q_reg <= ow_mem[ctrl.mac.w_addr[OW_AW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (ctrl.wr.feat_we) begin
            feat_mem[ctrl.wr.feat_addr] <= in_value;
        end
        feat_q_reg <= feat_mem[ctrl.mac.x_addr[FEAT_AW-1:0]];
    end

    // finalize: floor shift, bias, saturate
    always_comb begin
        fin_hid     = s3_reg.valid && s3_reg.last && (s3_reg.layer == LAYER_HID);
        fin_out     = s3_reg.valid && s3_reg.last && (s3_reg.layer == LAYER_OUT);
        acc_shifted = acc_reg >>> FRAC_BITS;
        biased      = (ACC_W+1)'(acc_shifted) +
                      (ACC_W+1)'((s3_reg.layer == LAYER_OUT) ? output_bias_reg
                                                             : hidden_bias_reg);
        priority if (biased < 0) begin
            hid_sat = '0;
        end else if (biased > HID_MAX) begin
            hid_sat = VAL_W'(HID_MAX);
        end else begin
            hid_sat = biased[VAL_W-1:0];
        end
        priority if (biased < LOGIT_MIN) begin
            logit_sat = LOGIT_W'(LOGIT_MIN);
        end else if (biased > LOGIT_MAX) begin
            logit_sat = LOGIT_W'(LOGIT_MAX);
        end else begin
            logit_sat = biased[LOGIT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (fin_hid) begin
            hval_mem[s3_reg.idx] <= hid_sat;
        end
        hval_q_reg <= hval_mem[ctrl.mac.x_addr[HID_AW-1:0]];
    end

    // MAC pipeline
    assign mul_a = (s1_reg.layer == LAYER_OUT) ? ow_q_reg : hw_q_reg;
    assign mul_b = (s1_reg.layer == LAYER_OUT) ? hval_q_reg : feat_q_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_reg.valid <= 1'b0;
            s2_reg.valid <= 1'b0;
            s3_reg.valid <= 1'b0;
        end else begin
            s1_reg.valid <= ctrl.mac.tag.valid;
            s2_reg.valid <= s1_reg.valid;
            s3_reg.valid <= s2_reg.valid;
        end
        s1_reg.layer <= ctrl.mac.tag.layer;
        s1_reg.first <= ctrl.mac.tag.first;
        s1_reg.last  <= ctrl.mac.tag.last;
        s1_reg.idx   <= ctrl.mac.tag.idx;
        s2_reg.layer <= s1_reg.layer;
        s2_reg.first <= s1_reg.first;
        s2_reg.last  <= s1_reg.last;
        s2_reg.idx   <= s1_reg.idx;
        s3_reg.layer <= s2_reg.layer;
        s3_reg.first <= s2_reg.first;
        s3_reg.last  <= s2_reg.last;
        s3_reg.idx   <= s2_reg.idx;
        prod_reg <= mul_a * mul_b;
        if (s2_reg.valid) begin
            acc_reg <= s2_reg.first ? ACC_W'(prod_reg) : acc_reg + ACC_W'(prod_reg);
        end
        if (fin_out) begin
            logit_reg[s3_reg.idx[0]] <= logit_sat;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (ctrl.load_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        if (ctrl.load_out) begin
            out_neg_reg <= logit_reg[0];
            out_pos_reg <= logit_reg[1];
            out_dec_reg <= (logit_reg[0] > logit_reg[1]) ? DEC_NEG : DEC_POS;
        end
    end

    assign status.busy     = s1_reg.valid | s2_reg.valid | s3_reg.valid;
    assign status.out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid      = m_tvalid_reg;
    assign out_logit_neg = out_neg_reg;
    assign out_logit_pos = out_pos_reg;
    assign out_decision  = out_dec_reg;

endmodule

>>> rtl/mlp_ctrl.sv
module mlp_ctrl
    import mlp_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    input  logic [MODE_W-1:0] in_mode,
    input  logic [WIDX_W-1:0] in_weight_index,
    output logic              in_ready,
    input  dp_status_t        status,
    output dp_ctrl_t          ctrl
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_HID   = 3'd1;
    localparam logic [2:0] ST_HWAIT = 3'd2;
    localparam logic [2:0] ST_OUTL  = 3'd3;
    localparam logic [2:0] ST_OWAIT = 3'd4;
    localparam logic [2:0] ST_EMIT  = 3'd5;

    logic [2:0]         state_reg, state_next;
    logic [FEAT_AW-1:0] fcnt_reg, fcnt_next;   // features received
    logic [FEAT_AW-1:0] f_reg, f_next;
    logic [HID_AW-1:0]  h_reg, h_next;
    logic               c_reg, c_next;
    logic [HW_AW-1:0]   hwa_reg, hwa_next;
    logic [OW_AW-1:0]   owa_reg, owa_next;
    logic               accept;

    // no transfer is taken while reset is held
    assign in_ready = aresetn && (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb begin
        state_next = state_reg;
        fcnt_next  = fcnt_reg;
        f_next     = f_reg;
        h_next     = h_reg;
        c_next     = c_reg;
        hwa_next   = hwa_reg;
        owa_next   = owa_reg;

        ctrl.wr.hw_we     = accept && (in_mode == MODE_HIDDEN_WEIGHT) &&
                            (32'(in_weight_index) < HW_DEPTH);
        ctrl.wr.ow_we     = accept && (in_mode == MODE_OUTPUT_WEIGHT) &&
                            (32'(in_weight_index) < OW_DEPTH);
        ctrl.wr.feat_we   = accept && (in_mode == MODE_FEATURE);
        ctrl.wr.feat_addr = fcnt_reg;
        ctrl.mac.tag.valid = 1'b0;
        ctrl.mac.tag.layer = LAYER_HID;
        ctrl.mac.tag.first = 1'b0;
        ctrl.mac.tag.last  = 1'b0;
        ctrl.mac.tag.idx   = h_reg;
        ctrl.mac.x_addr    = XA_W'(f_reg);
        ctrl.mac.w_addr    = hwa_reg;
        ctrl.load_out      = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (ctrl.wr.feat_we) begin
                    if (fcnt_reg == FEAT_AW'(FEATURES - 1)) begin
                        fcnt_next  = '0;
                        state_next = ST_HID;
                    end else begin
                        fcnt_next = fcnt_reg + 1'b1;
                    end
                end
            end
            ST_HID: begin
                ctrl.mac.tag.valid = 1'b1;
                ctrl.mac.tag.first = (f_reg == '0);
                ctrl.mac.tag.last  = (f_reg == FEAT_AW'(FEATURES - 1));
                hwa_next = hwa_reg + 1'b1;
                if (f_reg == FEAT_AW'(FEATURES - 1)) begin
                    f_next = '0;
                    if (h_reg == HID_AW'(HIDDEN_UNITS - 1)) begin
                        h_next     = '0;
                        hwa_next   = '0;
                        state_next = ST_HWAIT;
                    end else begin
                        h_next = h_reg + 1'b1;
                    end
                end else begin
                    f_next = f_reg + 1'b1;
                end
            end
            ST_HWAIT: begin
                // hidden values must be written back before the output layer reads them
                if (!status.busy) begin
                    state_next = ST_OUTL;
                end
            end
            ST_OUTL: begin
                ctrl.mac.tag.valid = 1'b1;
                ctrl.mac.tag.layer = LAYER_OUT;
                ctrl.mac.tag.first = (h_reg == '0);
                ctrl.mac.tag.last  = (h_reg == HID_AW'(HIDDEN_UNITS - 1));
                ctrl.mac.tag.idx   = HID_AW'(c_reg);
                ctrl.mac.x_addr    = XA_W'(h_reg);
                ctrl.mac.w_addr    = HW_AW'(owa_reg);
                owa_next = owa_reg + 1'b1;
                if (h_reg == HID_AW'(HIDDEN_UNITS - 1)) begin
                    h_next = '0;
                    if (c_reg == 1'(OUTPUTS - 1)) begin
                        c_next     = 1'b0;
                        owa_next   = '0;
                        state_next = ST_OWAIT;
                    end else begin
                        c_next = c_reg + 1'b1;
                    end
                end else begin
                    h_next = h_reg + 1'b1;
                end
            end
            ST_OWAIT: begin
                if (!status.busy) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    ctrl.load_out = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            fcnt_reg  <= '0;
            f_reg     <= '0;
            h_reg     <= '0;
            c_reg     <= 1'b0;
            hwa_reg   <= '0;
            owa_reg   <= '0;
        end else begin
            state_reg <= state_next;
            fcnt_reg  <= fcnt_next;
            f_reg     <= f_next;
            h_reg     <= h_next;
            c_reg     <= c_next;
            hwa_reg   <= hwa_next;
            owa_reg   <= owa_next;
        end
    end

endmodule

>>> rtl/mlp_relu_two_class_inference.sv
// Two-layer perceptron (ReLU hidden layer, two-class decision) in signed Q8.8.
// s_tuser selects the item kind: load a hidden weight (index h*FEATURES+f),
// load an output weight (index c*HIDDEN_UNITS+h) or deliver a feature. Weight
// loads and non-final features are written directly and leave the block idle
// for the next item. The last feature of an instance starts the compute pass
// on one shared 16x16 multiply-accumulate unit: 128 hidden products, a drain
// of the MAC pipeline, 16 output products, another drain and the load of the
// result register, during which s_tready is low; the load waits longer while
// the previous result is still held off by m_tready. s_tready is also low
// while reset is held.
// One result transfer follows each instance: both logits saturated to 24
// bits and the decision (0 neg when logit_neg > logit_pos, else 1 pos).
// The result sits in its own register, so the next instance may start while
// it waits for m_tready. Hidden sums are floored by 8 bits, biased and
// clamped to 0..32767; logits are floored, biased and clamped to 24 bits.
// Weights that were never loaded read as unknown. Bias registers (index 0
// hidden_bias, index 1 output_bias) reset to 1.0; the user must see that they
// are written through cfg_we only while the block is idle, as the block
// itself does not enforce this.
module mlp_relu_two_class_inference
    import mlp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration write port
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [VAL_W-1:0]      cfg_wdata,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // [6:0] weight_index, [22:7] value
    input  logic [MODE_W-1:0]     s_tuser,   // [1:0] mode
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata    // [23:0] logit_neg, [47:24] logit_pos,
                                             // [48] decision
);

    localparam int OUT_PAD = OUT_DATA_W - 2 * LOGIT_W - 1;

    dp_ctrl_t            ctrl;
    dp_status_t          status;
    logic [WIDX_W-1:0]   in_weight_index;
    logic [VAL_W-1:0]    in_value;
    logic signed [LOGIT_W-1:0] logit_neg, logit_pos;
    logic                decision;

    assign in_weight_index = s_tdata[WIDX_W-1:0];
    assign in_value        = s_tdata[WIDX_W+VAL_W-1:WIDX_W];

    mlp_ctrl u_ctrl (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_valid        (s_tvalid),
        .in_mode         (s_tuser),
        .in_weight_index (in_weight_index),
        .in_ready        (s_tready),
        .status          (status),
        .ctrl            (ctrl)
    );

    mlp_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .in_weight_index (in_weight_index),
        .in_value        (in_value),
        .ctrl            (ctrl),
        .status          (status),
        .m_tready        (m_tready),
        .m_tvalid        (m_tvalid),
        .out_logit_neg   (logit_neg),
        .out_logit_pos   (logit_pos),
        .out_decision    (decision)
    );

    assign m_tdata = {{OUT_PAD{1'b0}}, decision, logit_pos, logit_neg};

endmodule

>>> tb/mlp_relu_two_class_inference_test.sv
module mlp_relu_two_class_inference_test
    import mlp_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // mode 3 is not decoded by the block; it must be dropped silently
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    localparam int          RANDOM_ITEMS     = 1040;
    localparam int          SETTLE_CYCLES    = 200;  // > one full MAC pass
    localparam int          LONG_HOLD_CYCLES = 1500;
    localparam int          RX_PHASE_CYCLES  = 400;
    localparam longint      HIDDEN_MAX       = 2 ** (VAL_W - 1) - 1;
    localparam longint      LOGIT_MAX        = 2 ** (LOGIT_W - 1) - 1;
    localparam longint      LOGIT_MIN        = -(2 ** (LOGIT_W - 1));
    localparam logic [VAL_W-1:0] VAL_MAX     = 16'h7FFF;
    localparam logic [VAL_W-1:0] VAL_MIN     = 16'h8000;

    typedef struct {
        logic signed [LOGIT_W-1:0] neg;
        logic signed [LOGIT_W-1:0] pos;
        logic                      decision;
    } verdict_t;

    // ------------------------------------------------------------------
    // DUT hookup; every input has a known value from time zero
    // ------------------------------------------------------------------
    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic                  cfg_index = CFG_HIDDEN_BIAS;
    logic [VAL_W-1:0]      cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;   // [6:0] weight_index, [22:7] value
    logic [MODE_W-1:0]     s_tuser   = '0;   // [1:0] mode
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;          // [23:0] logit_neg, [47:24] logit_pos,
                                             // [48] decision

    mlp_relu_two_class_inference dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Shadow copy of the network: weights, feature buffer, biases
    // ------------------------------------------------------------------
    logic signed [VAL_W-1:0] hid_w    [HW_DEPTH];
    logic signed [VAL_W-1:0] out_w    [OW_DEPTH];
    logic signed [VAL_W-1:0] feat_buf [FEATURES];
    int unsigned             feat_cnt = 0;
    logic signed [VAL_W-1:0] hid_bias = 16'sd256;  // 1.0 after reset
    logic signed [VAL_W-1:0] out_bias = 16'sd256;

    verdict_t verdict_q [$];

    // run bookkeeping
    int unsigned n_fail        = 0;
    int unsigned n_effective   = 0;  // transfers that change state
    int unsigned n_ignored     = 0;
    int unsigned n_samples     = 0;
    int unsigned n_checked     = 0;
    int unsigned n_neg         = 0;
    int unsigned n_pos         = 0;
    int unsigned n_clamped     = 0;
    int unsigned n_cfg         = 0;
    int unsigned n_in_stalls   = 0;

    // sender burst control
    int unsigned gap_max    = 4;
    int unsigned burst_left = 0;

    // receiver long hold-off request (set on a rising edge, taken on a falling one)
    bit          long_hold_req = 1'b0;

    // ------------------------------------------------------------------
    // Predictor: full forward pass over the shadow network
    // ------------------------------------------------------------------
    function automatic verdict_t compute_verdict();
        longint   acc;
        longint   hidden [HIDDEN_UNITS];
        longint   lg     [OUTPUTS];
        verdict_t v;
        for (int h = 0; h < HIDDEN_UNITS; h++) begin
            acc = 0;
            for (int f = 0; f < FEATURES; f++)
                acc += longint'(feat_buf[f]) * longint'(hid_w[h * FEATURES + f]);
            // floor by 8 fraction bits, bias, then ReLU + saturate
            acc = (acc >>> FRAC_BITS) + longint'(hid_bias);
            hidden[h] = (acc < 0) ? 0 : ((acc > HIDDEN_MAX) ? HIDDEN_MAX : acc);
        end
        for (int c = 0; c < OUTPUTS; c++) begin
            acc = 0;
            for (int h = 0; h < HIDDEN_UNITS; h++)
                acc += hidden[h] * longint'(out_w[c * HIDDEN_UNITS + h]);
            acc = (acc >>> FRAC_BITS) + longint'(out_bias);
            lg[c] = (acc < LOGIT_MIN) ? LOGIT_MIN : ((acc > LOGIT_MAX) ? LOGIT_MAX : acc);
        end
        v.neg      = LOGIT_W'(lg[0]);
        v.pos      = LOGIT_W'(lg[1]);
        v.decision = (lg[0] > lg[1]) ? DEC_NEG : DEC_POS;
        return v;
    endfunction

    // ------------------------------------------------------------------
    // Send one item; caller sits on a falling edge, returns on one.
    // tvalid stays high on return so back-to-back transfers have no bubble.
    // ------------------------------------------------------------------
    task automatic send_item(input logic [MODE_W-1:0] mode,
                             input logic [WIDX_W-1:0] widx,
                             input logic [VAL_W-1:0]  val);
        int unsigned gap;
        int unsigned waits;
        if (burst_left == 0) begin
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;

        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {1'b0, val, widx};
        waits = 0;
        do begin
            @(posedge aclk);
            waits++;
        end while (!s_tready);
        if (waits > 1)
            n_in_stalls++;

        // transfer accepted: update the shadow state
        case (mode)
            MODE_HIDDEN_WEIGHT: begin
                hid_w[widx] = val;
                n_effective++;
            end
            MODE_OUTPUT_WEIGHT: begin
                if (widx < OW_DEPTH) begin
                    out_w[widx] = val;
                    n_effective++;
                end else begin
                    n_ignored++;   // out-of-range output weight address
                end
            end
            MODE_FEATURE: begin
                feat_buf[feat_cnt] = val;
                feat_cnt++;
                n_effective++;
                if (feat_cnt == FEATURES) begin
                    feat_cnt = 0;
                    n_samples++;
                    verdict_q.push_back(compute_verdict());
                end
            end
            default: n_ignored++;
        endcase
        @(negedge aclk);
    endtask

    // Park the sender, let all results come back, then let the MAC settle.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (verdict_q.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_bias(input logic idx, input logic [VAL_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        if (idx == CFG_HIDDEN_BIAS)
            hid_bias = val;
        else
            out_bias = val;
        n_cfg++;
    endtask

    // bias registers are only touched with the block idle
    task automatic set_biases(input logic [VAL_W-1:0] hb, input logic [VAL_W-1:0] ob);
        drain_results();
        write_bias(CFG_HIDDEN_BIAS, hb);
        write_bias(CFG_OUTPUT_BIAS, ob);
    endtask

    // mostly small Q8.8 values so sums stay in range, some extremes and raw noise
    function automatic logic [VAL_W-1:0] rand_value();
        case ($urandom_range(0, 9))
            0:       return VAL_MAX;
            1:       return VAL_MIN;
            2, 3:    return VAL_W'($urandom);
            default: return VAL_W'(int'($urandom_range(0, 1536)) - 768);
        endcase
    endfunction

    // Full network load. Random weights, or the saturating pattern:
    // every hidden weight at max, class 0 weights max, class 1 weights min.
    task automatic load_network(input bit extreme);
        for (int i = 0; i < HW_DEPTH; i++)
            send_item(MODE_HIDDEN_WEIGHT, WIDX_W'(i), extreme ? VAL_MAX : rand_value());
        for (int i = 0; i < OW_DEPTH; i++)
            send_item(MODE_OUTPUT_WEIGHT, WIDX_W'(i),
                      extreme ? ((i < HIDDEN_UNITS) ? VAL_MAX : VAL_MIN) : rand_value());
    endtask

    task automatic send_weight_update();
        if ($urandom_range(0, 1))
            send_item(MODE_HIDDEN_WEIGHT, WIDX_W'($urandom_range(0, HW_DEPTH - 1)),
                      rand_value());
        else
            send_item(MODE_OUTPUT_WEIGHT, WIDX_W'($urandom_range(0, OW_DEPTH - 1)),
                      rand_value());
    endtask

    task automatic send_sample();
        for (int f = 0; f < FEATURES; f++)
            send_item(MODE_FEATURE, WIDX_W'($urandom), rand_value());
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset biases, random network. Every weight is written before any
    // sample completes, so no unloaded entry is ever read.
    task automatic test_reset_biases();
        load_network(1'b0);
        repeat (2) send_sample();
    endtask

    // Hidden saturation at 32767, logits clamped both ways, ReLU cutting
    // negative sums (with floor rounding of a tiny negative), zero features,
    // and equal logits resolving to pos.
    task automatic test_saturation_and_relu();
        load_network(1'b1);
        repeat (FEATURES) send_item(MODE_FEATURE, '1, VAL_MAX);
        repeat (FEATURES) send_item(MODE_FEATURE, '0, VAL_MIN);   // all hidden -> 0
        repeat (FEATURES) send_item(MODE_FEATURE, '0, '0);        // hidden = bias
        for (int f = 0; f < FEATURES; f++)                        // sum slightly < 0
            send_item(MODE_FEATURE, '0, (f < FEATURES / 2) ? VAL_MAX : VAL_MIN);
        load_network(1'b0);
    endtask

    // Unused mode and out-of-range output-weight loads dropped mid-sample.
    task automatic test_ignored_items();
        for (int f = 0; f < FEATURES; f++) begin
            if (f == FEATURES / 2) begin
                send_item(MODE_UNUSED, '1, VAL_MAX);
                send_item(MODE_OUTPUT_WEIGHT, WIDX_W'(OW_DEPTH), VAL_MIN);
                send_item(MODE_OUTPUT_WEIGHT, '1, VAL_MAX);
                send_item(MODE_UNUSED, '0, '0);
            end
            send_item(MODE_FEATURE, WIDX_W'($urandom), rand_value());
        end
    endtask

    // Bias sweep through both extremes, zero, random and back to 1.0; a partial
    // sample is left pending across every write after the first.
    task automatic test_bias_settings();
        logic [VAL_W-1:0] hb [5];
        logic [VAL_W-1:0] ob [5];
        hb = '{VAL_MIN, VAL_MAX, 16'h0000, rand_value(), 16'h0100};
        ob = '{VAL_MAX, VAL_MIN, 16'h0000, rand_value(), 16'h0100};
        for (int s = 0; s < 5; s++) begin
            set_biases(hb[s], ob[s]);
            repeat (2) send_sample();
            repeat (5) send_item(MODE_FEATURE, WIDX_W'($urandom), rand_value());
        end
    endtask

    // Receiver holds off for a long stretch while samples keep coming with no
    // gaps: the result register fills, the next pass completes, s_tready drops.
    task automatic test_input_stall();
        int unsigned saved_gap;
        saved_gap = gap_max;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        long_hold_req = 1'b1;
        @(negedge aclk);
        gap_max = 0;
        repeat (4) send_sample();
        gap_max = saved_gap;
    endtask

    // Mostly complete samples with random content; weight updates, partial
    // runs, unused modes, bad addresses and an occasional bias change mixed in.
    task automatic test_random_traffic();
        int unsigned start;
        int unsigned pick;
        start = n_effective;
        while (n_effective - start < RANDOM_ITEMS) begin
            gap_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            pick    = $urandom_range(0, 99);
            if (pick < 65) begin
                for (int f = 0; f < FEATURES; f++) begin
                    if ($urandom_range(0, 15) == 0)
                        send_weight_update();
                    send_item(MODE_FEATURE, WIDX_W'($urandom), rand_value());
                end
            end else if (pick < 75) begin
                repeat ($urandom_range(1, FEATURES - 1))
                    send_item(MODE_FEATURE, WIDX_W'($urandom), rand_value());
            end else if (pick < 90) begin
                repeat ($urandom_range(1, 8))
                    send_weight_update();
            end else if (pick < 95) begin
                send_item(MODE_UNUSED, WIDX_W'($urandom), VAL_W'($urandom));
            end else begin
                send_item(MODE_OUTPUT_WEIGHT, WIDX_W'($urandom_range(OW_DEPTH, 127)),
                          VAL_W'($urandom));
            end
            if (pick >= 97)
                set_biases(rand_value(), rand_value());
        end
    endtask

    // ------------------------------------------------------------------
    // Result receiver: cycles through always-ready, random and periodic
    // stall patterns; a long hold-off overrides when requested.
    // ------------------------------------------------------------------
    int unsigned rx_cycle  = 0;
    int unsigned hold_left = 0;

    always @(negedge aclk) begin
        rx_cycle++;
        if (long_hold_req) begin
            hold_left     = LONG_HOLD_CYCLES;
            long_hold_req = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            case ((rx_cycle / RX_PHASE_CYCLES) % 3)
                0:       m_tready <= 1'b1;
                1:       m_tready <= ($urandom_range(0, 3) != 0);
                default: m_tready <= ((rx_cycle % 7) < 3);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Result checker: each result transfer against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        verdict_t                  want;
        logic signed [LOGIT_W-1:0] got_neg;
        logic signed [LOGIT_W-1:0] got_pos;
        logic                      got_dec;
        if (aresetn && m_tvalid && m_tready) begin
            got_neg = m_tdata[LOGIT_W-1:0];
            got_pos = m_tdata[2*LOGIT_W-1:LOGIT_W];
            got_dec = m_tdata[2*LOGIT_W];
            if (verdict_q.size() == 0) begin
                $error("result transfer with no completed sample pending");
                n_fail++;
            end else begin
                want = verdict_q.pop_front();
                n_checked++;
                if (want.decision == DEC_NEG)
                    n_neg++;
                else
                    n_pos++;
                if (want.neg == LOGIT_MAX || want.neg == LOGIT_MIN ||
                    want.pos == LOGIT_MAX || want.pos == LOGIT_MIN)
                    n_clamped++;
                if (got_neg !== want.neg) begin
                    $error("logit_neg: expected %0d, got %0d", want.neg, got_neg);
                    n_fail++;
                end
                if (got_pos !== want.pos) begin
                    $error("logit_pos: expected %0d, got %0d", want.pos, got_pos);
                    n_fail++;
                end
                if (got_dec !== want.decision) begin
                    $error("decision: expected %0d, got %0d", want.decision, got_dec);
                    n_fail++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_reset_biases();
        test_saturation_and_relu();
        test_ignored_items();
        test_bias_settings();
        test_input_stall();
        test_random_traffic();

        drain_results();

        $display("Run: %0d state-changing transfers, %0d ignored, %0d samples classified",
                 n_effective, n_ignored, n_samples);
        $display("Results: %0d checked (%0d neg, %0d pos, %0d clamped), %0d bias writes, %0d input stalls",
                 n_checked, n_neg, n_pos, n_clamped, n_cfg, n_in_stalls);
        if (n_fail == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #10_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

>>> files.f
rtl/mlp_pkg.sv
rtl/mlp_datapath.sv
rtl/mlp_ctrl.sv
rtl/mlp_relu_two_class_inference.sv
tb/mlp_relu_two_class_inference_test.sv
